[design/bed_pkg.sv]
`timescale 1ns / 1ps

package bed_pkg;

    localparam int WINDOW = 40;
    localparam int LAG    = 14;

    localparam int DEPTH  = WINDOW + 1;
    // offsets 1 .. WINDOW-LAG-1 are checked for a settled height
    localparam int NCHK   = WINDOW - LAG - 1;

    localparam int HEIGHT_W = 16;
    localparam int TIME_W   = 48;
    localparam int FILL_W   = $clog2(DEPTH + 1);

    typedef logic [HEIGHT_W-1:0] t_height;
    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [FILL_W-1:0]   t_fill;

    localparam t_height THR_RESET = t_height'(32);

endpackage

[design/bed_cell.sv]
`timescale 1ns / 1ps

module bed_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  bed_pkg::t_height i_height,
    input  bed_pkg::t_time   i_time,
    output bed_pkg::t_height o_height,
    output bed_pkg::t_time   o_time
);
    import bed_pkg::*;

    t_height r_height;
    t_time   r_time;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_height <= i_height;
            r_time   <= i_time;
        end
    end

    assign o_height = r_height;
    assign o_time   = r_time;

endmodule

[design/bed_match.sv]
`timescale 1ns / 1ps

module bed_match (
    input  bed_pkg::t_height i_height,
    input  bed_pkg::t_height i_lag_height,
    input  bed_pkg::t_height i_threshold,
    output logic             o_settled
);
    import bed_pkg::*;

    t_height w_diff;

    always_comb begin
        if (i_height > i_lag_height) begin
            w_diff = i_height - i_lag_height;
        end else begin
            w_diff = i_lag_height - i_height;
        end
    end

    assign o_settled = (w_diff < i_threshold);

endmodule

[design/blink_end_detector.sv]
`timescale 1ns / 1ps

// Blink end detector. Samples shift into a row of WINDOW+1 cells, newest at the
// top; once the row is full, each sample starts a check at the oldest cell.
// If that cell is closed (height zero) and the next one open, the first cell
// among offsets 1 .. WINDOW-LAG-1 whose height is within settle_threshold of
// the cell LAG places later gives the blink end timestamp. A sample passes
// through the shift on the transfer, a step in which all lag comparators are
// registered, and the first-match pick into the output register. The input
// is stalled from each transfer until the pick is done, and the pick waits
// while a result is held on a stalled output. The threshold port is always
// ready; write it only while the block is idle.
module blink_end_detector (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  bed_pkg::t_height i_pupil_height,
    input  bed_pkg::t_time   i_sample_time,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output bed_pkg::t_time   o_blink_end_time,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  bed_pkg::t_height i_cfg_data
);
    import bed_pkg::*;

    t_height w_h [DEPTH];
    t_time   w_t [DEPTH];
    logic [NCHK-1:0] w_settled;
    logic [NCHK-1:0] w_first;
    t_time   w_pick;
    logic    w_accept;
    logic    w_full;
    logic    w_open;
    logic    w_out_free;

    t_height r_threshold;
    t_fill   r_fill;
    logic    r_s0;
    logic    r_s1;
    logic    r_chk;
    logic [NCHK-1:0] r_flags;
    logic    r_out_valid;
    t_time   r_out_time;

    assign w_accept = i_in_valid && !o_in_stall;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == DEPTH - 1) begin : g_top
                bed_cell u_cell (
                    .i_clk    (i_clk),
                    .i_shift  (w_accept),
                    .i_height (i_pupil_height),
                    .i_time   (i_sample_time),
                    .o_height (w_h[g]),
                    .o_time   (w_t[g])
                );
            end else begin : g_mid
                bed_cell u_cell (
                    .i_clk    (i_clk),
                    .i_shift  (w_accept),
                    .i_height (w_h[g+1]),
                    .i_time   (w_t[g+1]),
                    .o_height (w_h[g]),
                    .o_time   (w_t[g])
                );
            end
        end
        for (g = 0; g < NCHK; g++) begin : g_match
            bed_match u_match (
                .i_height     (w_h[g+1]),
                .i_lag_height (w_h[g+1+LAG]),
                .i_threshold  (r_threshold),
                .o_settled    (w_settled[g])
            );
        end
    endgenerate

    assign w_full = (r_fill == t_fill'(DEPTH));
    assign w_open = (w_h[0] == '0) && (w_h[1] != '0);

    // isolate the lowest set flag, then or together the selected timestamps
    assign w_first = r_flags & ~(r_flags - NCHK'(1));

    always_comb begin
        w_pick = '0;
        for (int i = 0; i < NCHK; i++) begin
            w_pick = w_pick | (w_t[i+1] & {TIME_W{w_first[i]}});
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_threshold <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_s0        <= 1'b0;
            r_s1        <= 1'b0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s0 <= 1'b1;
                if (!w_full) begin
                    r_fill <= r_fill + t_fill'(1);
                end
            end
            if (r_s0) begin
                r_s0  <= 1'b0;
                r_s1  <= 1'b1;
                r_chk <= w_full && w_open;
            end
            // a free output slot is either empty or being taken this cycle
            if (r_s1 && w_out_free) begin
                r_s1        <= 1'b0;
                r_out_valid <= r_chk && (r_flags != '0);
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s0) begin
            r_flags <= w_settled;
        end
        if (r_s1 && w_out_free) begin
            r_out_time <= w_pick;
        end
    end

    assign o_in_stall       = r_s0 || r_s1;
    assign o_out_valid      = r_out_valid;
    assign o_blink_end_time = r_out_time;
    assign o_cfg_ready      = 1'b1;

endmodule

[design/bed_checker.sv]
`timescale 1ns / 1ps

module bed_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input bed_pkg::t_time   o_blink_end_time
);
    import bed_pkg::*;

    // one sample at a time: a transfer always blocks the next cycle
    a_stall_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transfer");

    // a fresh result only comes out of a busy pipeline
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a sample in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_blink_end_time)))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_in_stall && !o_out_valid))
        else $error("block not idle after reset");

endmodule

bind blink_end_detector bed_checker u_bed_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_blink_end_time (o_blink_end_time)
);

[tb/sv/tb_blink_end_detector.sv]
`timescale 1ns / 1ps

module tb_blink_end_detector;
    import bed_pkg::*;

    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int RANDOM_ITEMS   = 450;
    localparam int PHASE_ITEMS    = 75;

    typedef t_height t_height_run[$];

    logic    i_clk;
    logic    i_rst_n          = 1'b0;
    logic    i_in_valid       = 1'b0;
    logic    o_in_stall;
    t_height i_pupil_height   = '0;
    t_time   i_sample_time    = '0;
    logic    o_out_valid;
    logic    i_out_stall      = 1'b0;
    t_time   o_blink_end_time;
    logic    i_cfg_valid      = 1'b0;
    logic    o_cfg_ready;
    t_height i_cfg_data       = '0;

    // predictor state
    t_height window_heights[$];
    t_time   window_times[$];
    t_height settle_thr = THR_RESET;
    t_time   pending_blink_ends[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned n_sent         = 0;
    int unsigned n_blink_ends   = 0;
    int unsigned n_thr_writes   = 0;
    int unsigned n_errors       = 0;
    int unsigned cycle_cnt      = 0;

    blink_end_detector dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pupil_height   (i_pupil_height),
        .i_sample_time    (i_sample_time),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_blink_end_time (o_blink_end_time),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > TIMEOUT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_blink_ends
        t_time want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_blink_ends.size() == 0) begin
                $error("blink_end_time: expected none, actual %0h", o_blink_end_time);
                n_errors++;
            end else begin
                want = pending_blink_ends.pop_front();
                n_blink_ends++;
                if (o_blink_end_time !== want) begin
                    $error("blink_end_time: expected %0h, actual %0h", want,
                           o_blink_end_time);
                    n_errors++;
                end
            end
        end
    end

    function automatic t_time random_time();
        return t_time'({$urandom, $urandom});
    endfunction

    // shift the sample in, then look for an opening at the oldest cell
    function automatic void predict_blink_end(input t_height h, input t_time t);
        int unsigned gap;
        window_heights = {window_heights, h};
        window_times   = {window_times, t};
        if (window_heights.size() > DEPTH) begin
            window_heights.delete(0);
            window_times.delete(0);
        end
        if (window_heights.size() != DEPTH)
            return;
        if (window_heights[0] != '0 || window_heights[1] == '0)
            return;
        for (int k = 1; k + LAG < WINDOW; k++) begin
            gap = (window_heights[k] > window_heights[k + LAG]) ?
                  window_heights[k] - window_heights[k + LAG] :
                  window_heights[k + LAG] - window_heights[k];
            if (gap < settle_thr) begin
                pending_blink_ends = {pending_blink_ends, window_times[k]};
                return;
            end
        end
    endfunction

    task automatic send_sample(input t_height h, input t_time t);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_pupil_height <= h;
        i_sample_time  <= t;
        do @(posedge i_clk); while (o_in_stall);
        predict_blink_end(h, t);
        n_sent++;
    endtask

    task automatic send_run(input t_height_run hs);
        foreach (hs[j])
            send_sample(hs[j], random_time());
    endtask

    // closed cell, then a steep rise so that no pair settles, except the pair
    // at settle_k which is given the height difference gap
    function automatic t_height_run opening_run(input int settle_k, input int gap);
        t_height_run q;
        q = {q, t_height'(0)};
        for (int j = 1; j < DEPTH; j++)
            q = {q, t_height'(1000 * (j + 1))};
        if (settle_k > 0)
            q[settle_k + LAG] = t_height'(int'(q[settle_k]) + gap);
        return q;
    endfunction

    // wait for every result, then for the pipeline to empty
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_blink_ends.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input t_height v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        settle_thr = v;
        n_thr_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_window_fill();
        // no check until the window is full; first check sees full-scale heights
        send_sample('0, '0);
        send_sample('1, '1);
        repeat (DEPTH - 2)
            send_sample('1, random_time());
    endtask

    task automatic test_settle_offsets();
        t_height_run q;
        send_run(opening_run(1, 0));
        send_run(opening_run(WINDOW - LAG - 1, 0));
        send_run(opening_run(WINDOW - LAG, 0));
        send_run(opening_run(5, int'(settle_thr) - 1));
        send_run(opening_run(5, int'(settle_thr)));
        send_run(opening_run(0, 0));
        // two closed cells in a row
        q = opening_run(3, 0);
        q[1] = '0;
        send_run(q);
    endtask

    task automatic test_threshold_extremes();
        t_height_run q;
        t_height     full_scale;
        full_scale = '1;
        write_threshold('0);
        send_run(opening_run(1, 0));
        write_threshold('1);
        // every pair differs by full scale, which is not below the top threshold
        q = {q, t_height'(0)};
        for (int j = 1; j < DEPTH; j++)
            q = {q, ((((j - 1) / LAG) % 2 == 0) ? full_scale : t_height'(0))};
        send_run(q);
        send_run(opening_run(2, 0));
    endtask

    task automatic send_blink();
        int          v;
        int unsigned noise;
        t_height     level;
        repeat ($urandom_range(1, 4))
            send_sample('0, random_time());
        repeat ($urandom_range(0, 3))
            send_sample(t_height'($urandom_range(1, 65535)), random_time());
        level = t_height'($urandom_range(1, 65535));
        case ($urandom_range(0, 3))
            0: noise = 0;
            1: noise = 3;
            2: noise = 20;
            default: noise = 400;
        endcase
        repeat ($urandom_range(10, 32)) begin
            v = int'(level) + int'($urandom_range(0, 2 * noise)) - int'(noise);
            if (v < 1)
                v = 1;
            if (v > 65535)
                v = 65535;
            send_sample(t_height'(v), random_time());
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 20)) begin
            if ($urandom_range(0, 3) == 0)
                send_sample('0, random_time());
            else
                send_sample(t_height'($urandom), random_time());
        end
    endtask

    task automatic test_random_traffic();
        int unsigned first_sent;
        int unsigned phase_start;
        int          phase;
        first_sent = n_sent;
        phase = 0;
        while (n_sent - first_sent < RANDOM_ITEMS && phase < 30) begin
            case (phase % 6)
                0: write_threshold(t_height'(1));
                1: write_threshold('1);
                2: write_threshold(t_height'($urandom));
                3: write_threshold('0);
                4: write_threshold(THR_RESET);
                default: write_threshold(t_height'($urandom_range(1, 255)));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            phase_start = n_sent;
            // mostly well-formed blinks, the rest arbitrary samples
            while (n_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 80)
                    send_blink();
                else
                    send_noise();
            end
            phase++;
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_window_fill();
        test_settle_offsets();
        test_threshold_extremes();
        test_random_traffic();

        drain();
        $display("covered %0d samples, %0d blink ends checked, %0d threshold writes",
                 n_sent, n_blink_ends, n_thr_writes);
        if (n_errors == 0 && pending_blink_ends.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
